@@ src/fddp_pkg.sv @@
// Shared types, codes and the header plan functions for the frame dibit demux planner.
// No dependencies; imported by the channel interfaces and the top level.
package fddp_pkg;

  // Field widths
  localparam int KIND_W = 2;
  localparam int FI_W   = 2;
  localparam int FN_W   = 3;
  localparam int DT_W   = 2;
  localparam int CH_W   = 2;
  localparam int POS_W  = 9;
  localparam int TAG_W  = 4;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 4;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd2;

  // Frame indicator codes
  localparam logic [FI_W-1:0] FI_HEADER = 2'd0;
  localparam logic [FI_W-1:0] FI_COMM   = 2'd1;
  localparam logic [FI_W-1:0] FI_TERM   = 2'd2;

  // Data type codes
  localparam logic [DT_W-1:0] DT_DATA_FR  = 2'b01;
  localparam logic [DT_W-1:0] DT_VD2      = 2'b10;
  localparam logic [DT_W-1:0] DT_VOICE_FR = 2'b11;

  // Frame numbers that pick the data frame tag pair
  localparam logic [FN_W-1:0] FN_FIRST  = 3'd0;
  localparam logic [FN_W-1:0] FN_SECOND = 3'd1;

  // Planner modes
  localparam logic [MODE_W-1:0] MODE_DONE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STALL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PENDING = 2'd2;

  // Channels
  localparam logic [CH_W-1:0] CH_VD1 = 2'd0;
  localparam logic [CH_W-1:0] CH_VD2 = 2'd1;
  localparam logic [CH_W-1:0] CH_VDV = 2'd2;
  localparam logic [CH_W-1:0] CH_FRV = 2'd3;

  // Tags
  localparam logic [TAG_W-1:0] TG_NONE = 4'd0;
  localparam logic [TAG_W-1:0] TG_CSD1 = 4'd1;
  localparam logic [TAG_W-1:0] TG_CSD2 = 4'd2;
  localparam logic [TAG_W-1:0] TG_CSD3 = 4'd3;
  localparam logic [TAG_W-1:0] TG_DT   = 4'd4;
  localparam logic [TAG_W-1:0] TG_DEST = 4'd5;

  // Block geometry in dibits
  localparam logic [POS_W-1:0] BLK_VD1 = POS_W'(72 / 2);
  localparam logic [POS_W-1:0] BLK_VD  = POS_W'(144 / 2);
  localparam logic [POS_W-1:0] LEN_VD2 = POS_W'(40 / 2);
  localparam logic [POS_W-1:0] LEN_VDV = POS_W'(104 / 2);

  localparam logic [IDX_W-1:0] PLAN_VD1_LEN   = 4'd12;
  localparam logic [IDX_W-1:0] PLAN_VD2_LEN   = 4'd10;
  localparam logic [IDX_W-1:0] PLAN_FRV_LEN   = 4'd5;
  localparam logic [FN_W-1:0]  FN_LAST_TAG    = 3'd5;

  // One queued segment; stop is exclusive
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] stop;
    logic [TAG_W-1:0] tag;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  // Layout that uses the VD1 block pair scheme
  function automatic logic is_vd1_plan(input logic [FI_W-1:0] fi, input logic [DT_W-1:0] dt);
    is_vd1_plan = (fi == FI_HEADER) || (fi == FI_TERM) || ((fi == FI_COMM) && (dt == DT_DATA_FR));
  endfunction

  // Number of segments a header appends
  function automatic logic [IDX_W-1:0] plan_len(input logic [FI_W-1:0] fi,
                                               input logic [FN_W-1:0] fn,
                                               input logic [DT_W-1:0] dt);
    logic [IDX_W-1:0] n;
    n = '0;
    if (is_vd1_plan(fi, dt)) begin
      n = PLAN_VD1_LEN;
    end else if ((fi == FI_COMM) && (dt == DT_VD2)) begin
      n = (fn <= FN_LAST_TAG) ? PLAN_VD2_LEN + 4'd1 : PLAN_VD2_LEN;
    end else if ((fi == FI_COMM) && (dt == DT_VOICE_FR)) begin
      n = PLAN_FRV_LEN;
    end
    return n;
  endfunction

  // Segment number idx of the header plan
  function automatic seg_t plan_seg(input logic [FI_W-1:0] fi,
                                    input logic [FN_W-1:0] fn,
                                    input logic [DT_W-1:0] dt,
                                    input logic [IDX_W-1:0] idx);
    seg_t s;
    logic [TAG_W-1:0] t1;
    logic [TAG_W-1:0] t2;
    logic [POS_W-1:0] b;
    logic [IDX_W-1:0] k;
    logic has_tag;
    s = '0;
    t1 = TG_CSD1;
    t2 = TG_CSD2;
    b = '0;
    k = '0;
    has_tag = 1'b0;
    if (is_vd1_plan(fi, dt)) begin
      // pick the tag pair from FN on communication frames
      if (fi == FI_COMM) begin
        case (fn)
          FN_FIRST: begin
            t1 = TG_CSD1;
            t2 = TG_CSD2;
          end
          FN_SECOND: begin
            t1 = TG_CSD3;
            t2 = TG_DT;
          end
          default: begin
            t1 = TG_DT;
            t2 = TG_DT;
          end
        endcase
      end
      s.ch = CH_VD1;
      if (idx == 4'd0) begin
        s.pos = '0;
        s.stop = 9'd1;
        s.tag = t1;
      end else if (idx < 4'd6) begin
        b = {4'b0, idx - 4'd1, 1'b0};
        s.pos = POS_W'(b * BLK_VD1);
        s.stop = POS_W'(b * BLK_VD1 + BLK_VD1);
      end else if (idx == 4'd6) begin
        s.pos = '0;
        s.stop = 9'd1;
        s.tag = t2;
      end else begin
        b = {4'b0, idx - 4'd7, 1'b1};
        s.pos = POS_W'(b * BLK_VD1);
        s.stop = POS_W'(b * BLK_VD1 + BLK_VD1);
      end
    end else if ((fi == FI_COMM) && (dt == DT_VD2)) begin
      has_tag = (fn <= FN_LAST_TAG);
      if (has_tag && (idx == 4'd0)) begin
        s.ch = CH_VD2;
        s.pos = '0;
        s.stop = 9'd1;
        s.tag = TAG_W'(TG_DEST + {1'b0, fn});
      end else begin
        k = idx - {3'b0, has_tag};
        b = {6'b0, k[3:1]};
        if (!k[0]) begin
          s.ch = CH_VD2;
          s.pos = POS_W'(b * BLK_VD);
          s.stop = POS_W'(b * BLK_VD + LEN_VD2);
        end else begin
          s.ch = CH_VDV;
          s.pos = POS_W'(b * BLK_VD + LEN_VD2);
          s.stop = POS_W'(b * BLK_VD + LEN_VD2 + LEN_VDV);
        end
      end
    end else if ((fi == FI_COMM) && (dt == DT_VOICE_FR)) begin
      b = {5'b0, idx};
      s.ch = CH_FRV;
      s.pos = POS_W'(b * BLK_VD);
      s.stop = POS_W'(b * BLK_VD + BLK_VD);
    end
    return s;
  endfunction

endpackage

@@ src/fddp_if.sv @@
// Valid/ready channel interfaces for the planner's input and result items.
// Depends on fddp_pkg for the field widths.
interface fddp_in_if import fddp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [FI_W-1:0]   frame_indicator;
  logic [FN_W-1:0]   frame_number;
  logic [DT_W-1:0]   data_type;

  modport source (output valid, kind, frame_indicator, frame_number, data_type,
                  input ready);
  modport sink (input valid, kind, frame_indicator, frame_number, data_type,
                output ready);
endinterface

interface fddp_out_if import fddp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [CH_W-1:0]   channel;
  logic [POS_W-1:0]  position;
  logic [TAG_W-1:0]  tag;
  logic [MODE_W-1:0] mode_state;
  logic              overflow;

  modport source (output valid, valid_res, channel, position, tag, mode_state, overflow,
                  input ready);
  modport sink (input valid, valid_res, channel, position, tag, mode_state, overflow,
                output ready);
endinterface

@@ src/frame_dibit_demux_planner.sv @@
// Frame dibit demux planner: segment queue in a one-port-write, registered-read memory.
// Depends on fddp_pkg and the channel interfaces in fddp_if.sv.
// Path, accept to result valid: an appended header (N segments, up to 12) via S_WRITE,
// then S_RESP; a dropped or empty header, arm or empty-queue tick via S_RESP; other ticks
// via S_TICK, then S_RESP. One item at a time; one header segment written per cycle.
// Reset: synchronous, queue empty and mode done; queue memory is not cleared.
module frame_dibit_demux_planner import fddp_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  fddp_in_if.sink    in_bus,
  fddp_out_if.source out_bus
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_TICK,
    S_RESP
  } state_t;

  state_t            state_r;
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;
  logic [MODE_W-1:0] mode_r;

  // latched header fields and write progress
  logic [FI_W-1:0]   fi_r;
  logic [FN_W-1:0]   fn_r;
  logic [DT_W-1:0]   dt_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  len_r;

  // pending result
  logic              res_valid_r;
  logic [CH_W-1:0]   res_ch_r;
  logic [POS_W-1:0]  res_pos_r;
  logic [TAG_W-1:0]  res_tag_r;
  logic              res_ovf_r;

  // output register
  logic              out_valid_r;
  logic              out_vres_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [MODE_W-1:0] out_mode_r;
  logic              out_ovf_r;

  // queue memory
  seg_t              mem_r [QUEUE_DEPTH];
  seg_t              rd_data_r;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  seg_t              wr_data;

  logic              accept;
  logic [IDX_W-1:0]  in_len;
  logic [CNT_W-1:0]  room;
  logic              fits;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;
  logic              last_pos;
  logic              out_free;

  assign accept   = in_bus.valid && in_bus.ready;
  assign in_len   = plan_len(in_bus.frame_indicator, in_bus.frame_number, in_bus.data_type);
  assign room     = CNT_W'(QUEUE_DEPTH) - count_r;
  assign fits     = CNT_W'(in_len) <= room;
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign last_pos = ({1'b0, rd_data_r.pos} + 10'd1) >= {1'b0, rd_data_r.stop};
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready = (state_r == S_IDLE);

  // Select the single memory write: plan append or tick write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail_r;
    wr_data = plan_seg(fi_r, fn_r, dt_r, idx_r);
    case (state_r)
      S_WRITE: begin
        wr_en = 1'b1;
      end
      S_TICK: begin
        wr_en        = !last_pos;
        wr_addr      = head_r;
        wr_data      = rd_data_r;
        wr_data.pos  = rd_data_r.pos + 1'b1;
        wr_data.tag  = TG_NONE;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Read the head entry every cycle; writes never touch the head while a tick is read,
  // since items are taken one at a time and a write is always followed by a response cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[head_r];
  end

  // Sequence one item: plan writes, tick read-modify-write, then hand off the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      mode_r      <= MODE_DONE;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output once taken
      if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            fi_r        <= in_bus.frame_indicator;
            fn_r        <= in_bus.frame_number;
            dt_r        <= in_bus.data_type;
            idx_r       <= '0;
            len_r       <= in_len;
            res_valid_r <= 1'b0;
            res_ch_r    <= '0;
            res_pos_r   <= '0;
            res_tag_r   <= '0;
            res_ovf_r   <= 1'b0;
            state_r     <= S_RESP;
            case (in_bus.kind)
              KIND_HEADER: begin
                if ((in_len != '0) && fits) begin
                  state_r <= S_WRITE;
                end else begin
                  res_ovf_r <= !fits;
                  mode_r    <= (count_r == '0) ? MODE_DONE : MODE_PENDING;
                end
              end
              KIND_TICK: begin
                if (count_r != '0) begin
                  state_r <= S_TICK;
                end
              end
              KIND_ARM: begin
                mode_r <= MODE_STALL;
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_WRITE: begin
          // append one segment per cycle
          tail_r  <= tail_inc;
          count_r <= count_r + 1'b1;
          idx_r   <= idx_r + 1'b1;
          if (idx_r == len_r - 4'd1) begin
            mode_r  <= MODE_PENDING;
            state_r <= S_RESP;
          end
        end
        S_TICK: begin
          res_valid_r <= 1'b1;
          res_ch_r    <= rd_data_r.ch;
          res_pos_r   <= rd_data_r.pos;
          res_tag_r   <= rd_data_r.tag;
          if (last_pos) begin
            // pop the finished segment
            head_r  <= head_inc;
            count_r <= count_r - 1'b1;
            mode_r  <= (count_r == CNT_W'(1)) ? MODE_DONE : MODE_PENDING;
          end else begin
            mode_r <= MODE_PENDING;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_vres_r  <= res_valid_r;
            out_ch_r    <= res_ch_r;
            out_pos_r   <= res_pos_r;
            out_tag_r   <= res_tag_r;
            out_mode_r  <= mode_r;
            out_ovf_r   <= res_ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.valid_res  = out_vres_r;
  assign out_bus.channel    = out_ch_r;
  assign out_bus.position   = out_pos_r;
  assign out_bus.tag        = out_tag_r;
  assign out_bus.mode_state = out_mode_r;
  assign out_bus.overflow   = out_ovf_r;

  // Queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // Empty queue has matching pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  // A tick that found a segment never reports the stalled mode
  a_tick_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vres_r) |-> (out_mode_r != MODE_STALL))
    else $error("tick result reports stalled mode");

  // Overflow and a tick hit never share one result
  a_ovf_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_vres_r && out_ovf_r))
    else $error("overflow flagged on tick result");

  // A header only writes after it was checked to fit
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("plan write into full queue");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for frame_dibit_demux_planner.
// Depends on fddp_pkg and the channel interfaces in fddp_if.sv. A built-in
// segment queue predictor checks every result item field by field.
module tb;
  import fddp_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int IDLE_PCT       = 9;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_CHUNKS  = 11;
  localparam int CHUNK_ITEMS    = 100;

  // Codes the package leaves unnamed
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [FI_W-1:0]   FI_UNKNOWN  = 2'd3;
  localparam logic [DT_W-1:0]   DT_UNKNOWN  = 2'd0;
  localparam logic [FN_W-1:0]   FN_MAX      = 3'd7;

  typedef struct packed {
    logic              valid_res;
    logic [CH_W-1:0]   channel;
    logic [POS_W-1:0]  position;
    logic [TAG_W-1:0]  tag;
    logic [MODE_W-1:0] mode_state;
    logic              overflow;
  } dibit_result_t;

  logic clk = 1'b0;
  logic rst_n;

  fddp_in_if  in_bus ();
  fddp_out_if out_bus ();

  frame_dibit_demux_planner #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Predictor state: segment queue and planner mode
  seg_t              seg_store [QUEUE_DEPTH];
  int                seg_head;
  int                seg_tail;
  int                seg_count;
  logic [MODE_W-1:0] planner_mode_q;
  seg_t              frame_plan [$];

  dibit_result_t expected_results [$];
  int            error_count  = 0;
  logic          idle_enabled = 1'b1;
  int            stuck_cycles = 0;

  logic [FI_W-1:0] known_fi [3] = '{FI_HEADER, FI_COMM, FI_TERM};
  logic [DT_W-1:0] known_dt [3] = '{DT_DATA_FR, DT_VD2, DT_VOICE_FR};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append one segment to the plan being built
  function automatic void add_segment(input logic [CH_W-1:0] ch, input int first,
                                      input int stop, input logic [TAG_W-1:0] tag);
    seg_t s;
    s.ch   = ch;
    s.pos  = POS_W'(first);
    s.stop = POS_W'(stop);
    s.tag  = tag;
    frame_plan.push_back(s);
  endfunction

  // Tagged position 0 then even blocks, tagged position 0 then odd blocks
  function automatic void plan_vd1_blocks(input logic [TAG_W-1:0] first_tag,
                                          input logic [TAG_W-1:0] second_tag);
    add_segment(CH_VD1, 0, 1, first_tag);
    for (int i = 0; i < 10; i += 2)
      add_segment(CH_VD1, i * int'(BLK_VD1), (i + 1) * int'(BLK_VD1), TG_NONE);
    add_segment(CH_VD1, 0, 1, second_tag);
    for (int i = 1; i < 10; i += 2)
      add_segment(CH_VD1, i * int'(BLK_VD1), (i + 1) * int'(BLK_VD1), TG_NONE);
  endfunction

  function automatic void build_frame_plan(input logic [FI_W-1:0] fi,
                                           input logic [FN_W-1:0] fn,
                                           input logic [DT_W-1:0] dt);
    int base;
    frame_plan.delete();
    if (fi == FI_HEADER || fi == FI_TERM) begin
      plan_vd1_blocks(TG_CSD1, TG_CSD2);
    end else if (fi == FI_COMM) begin
      if (dt == DT_DATA_FR) begin
        if (fn == FN_FIRST) plan_vd1_blocks(TG_CSD1, TG_CSD2);
        else if (fn == FN_SECOND) plan_vd1_blocks(TG_CSD3, TG_DT);
        else plan_vd1_blocks(TG_DT, TG_DT);
      end else if (dt == DT_VD2) begin
        if (fn <= FN_LAST_TAG) add_segment(CH_VD2, 0, 1, TG_DEST + TAG_W'(fn));
        for (int i = 0; i < 5; i++) begin
          base = i * int'(BLK_VD);
          add_segment(CH_VD2, base, base + int'(LEN_VD2), TG_NONE);
          add_segment(CH_VDV, base + int'(LEN_VD2),
                      base + int'(LEN_VD2) + int'(LEN_VDV), TG_NONE);
        end
      end else if (dt == DT_VOICE_FR) begin
        for (int i = 0; i < 5; i++)
          add_segment(CH_FRV, i * int'(BLK_VD), (i + 1) * int'(BLK_VD), TG_NONE);
      end
    end
  endfunction

  // Advance the predictor by one accepted item and return its result
  function automatic dibit_result_t predict_dibit_result(input logic [KIND_W-1:0] kind,
                                                         input logic [FI_W-1:0] fi,
                                                         input logic [FN_W-1:0] fn,
                                                         input logic [DT_W-1:0] dt);
    dibit_result_t r;
    seg_t head_seg;
    r = '0;
    case (kind)
      KIND_HEADER: begin
        build_frame_plan(fi, fn, dt);
        if (frame_plan.size() > QUEUE_DEPTH - seg_count) begin
          r.overflow = 1'b1;
        end else begin
          foreach (frame_plan[i]) begin
            seg_store[seg_tail] = frame_plan[i];
            seg_tail = (seg_tail + 1) % QUEUE_DEPTH;
            seg_count++;
          end
        end
        planner_mode_q = (seg_count == 0) ? MODE_DONE : MODE_PENDING;
      end
      KIND_TICK: begin
        if (seg_count != 0) begin
          head_seg    = seg_store[seg_head];
          r.valid_res = 1'b1;
          r.channel   = head_seg.ch;
          r.position  = head_seg.pos;
          r.tag       = head_seg.tag;
          // pop at the last position, else step and clear the tag
          if (int'(head_seg.pos) + 1 >= int'(head_seg.stop)) begin
            seg_head = (seg_head + 1) % QUEUE_DEPTH;
            seg_count--;
          end else begin
            seg_store[seg_head].pos = head_seg.pos + 1'b1;
            seg_store[seg_head].tag = TG_NONE;
          end
          planner_mode_q = (seg_count == 0) ? MODE_DONE : MODE_PENDING;
        end
      end
      KIND_ARM: planner_mode_q = MODE_STALL;
      default: ;
    endcase
    r.mode_state = planner_mode_q;
    return r;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  // Drive one item, hold it until accepted, then queue its expected result
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [FI_W-1:0] fi,
                           input logic [FN_W-1:0] fn, input logic [DT_W-1:0] dt);
    while (idle_enabled && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.kind            <= kind;
    in_bus.frame_indicator <= fi;
    in_bus.frame_number    <= fn;
    in_bus.data_type       <= dt;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    expected_results.push_back(predict_dibit_result(kind, fi, fn, dt));
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Empty queue: tick, arm, unused kind and unknown headers
  task automatic test_empty_queue();
    send_item(KIND_TICK, FI_UNKNOWN, FN_MAX, DT_VOICE_FR);
    send_item(KIND_ARM, FI_HEADER, FN_FIRST, DT_UNKNOWN);
    send_item(KIND_TICK, FI_HEADER, FN_FIRST, DT_UNKNOWN);
    send_item(KIND_UNUSED, FI_UNKNOWN, FN_MAX, DT_VOICE_FR);
    send_item(KIND_HEADER, FI_UNKNOWN, FN_MAX, DT_VOICE_FR);
    send_item(KIND_HEADER, FI_COMM, FN_MAX, DT_UNKNOWN);
  endtask

  // Every header type; all known plans after the first header and the voice plan overflow
  task automatic test_header_plans();
    send_item(KIND_HEADER, FI_HEADER, FN_FIRST, DT_UNKNOWN);
    send_item(KIND_TICK, FI_HEADER, FN_FIRST, DT_UNKNOWN);
    send_item(KIND_TICK, FI_UNKNOWN, FN_MAX, DT_VOICE_FR);
    send_item(KIND_HEADER, FI_TERM, FN_MAX, DT_VOICE_FR);
    send_item(KIND_HEADER, FI_COMM, FN_MAX, DT_VOICE_FR);
    send_item(KIND_HEADER, FI_COMM, FN_FIRST, DT_DATA_FR);
    send_item(KIND_HEADER, FI_COMM, FN_SECOND, DT_DATA_FR);
    send_item(KIND_HEADER, FI_COMM, FN_MAX, DT_DATA_FR);
    send_item(KIND_HEADER, FI_COMM, FN_FIRST, DT_VD2);
    send_item(KIND_HEADER, FI_COMM, FN_LAST_TAG, DT_VD2);
    send_item(KIND_HEADER, FI_COMM, FN_MAX, DT_VD2);
    send_item(KIND_ARM, FI_COMM, FN_MAX, DT_VD2);
    send_item(KIND_TICK, FI_COMM, FN_MAX, DT_VD2);
    send_item(KIND_HEADER, FI_UNKNOWN, FN_FIRST, DT_UNKNOWN);
    send_item(KIND_HEADER, FI_COMM, FN_SECOND, DT_UNKNOWN);
  endtask

  // Tick the queue empty, hold off until all results are in, then tick once more
  task automatic test_drain_and_pause();
    while (seg_count != 0)
      send_item(KIND_TICK, FI_W'($urandom), FN_W'($urandom), DT_W'($urandom));
    in_bus.valid <= 1'b0;
    wait_for_results();
    @(posedge clk);
    send_item(KIND_TICK, FI_W'($urandom), FN_W'($urandom), DT_W'($urandom));
  endtask

  // Mixed traffic; header rate and idling vary from chunk to chunk
  task automatic test_random_traffic();
    int counted;
    int header_pct;
    int roll;
    logic [KIND_W-1:0] kind;
    logic [FI_W-1:0] fi;
    logic [FN_W-1:0] fn;
    logic [DT_W-1:0] dt;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      case ($urandom_range(0, 2))
        0: header_pct = 3;
        1: header_pct = 12;
        default: header_pct = 30;
      endcase
      idle_enabled = !(chunk >= 4 && chunk < 7);
      counted = 0;
      while (counted < CHUNK_ITEMS) begin
        roll = $urandom_range(0, 99);
        fi = FI_W'($urandom);
        fn = FN_W'($urandom);
        dt = DT_W'($urandom);
        if (roll < header_pct) begin
          kind = KIND_HEADER;
          // mostly known frame types, some unknown
          if ($urandom_range(0, 9) != 0) begin
            fi = known_fi[$urandom_range(0, 2)];
            if (fi == FI_COMM) dt = known_dt[$urandom_range(0, 2)];
          end
        end else if (roll < header_pct + 6) begin
          kind = KIND_ARM;
        end else if (roll < header_pct + 9) begin
          kind = KIND_UNUSED;
        end else begin
          kind = KIND_TICK;
        end
        send_item(kind, fi, fn, dt);
        if (kind != KIND_UNUSED) counted++;
      end
    end
    idle_enabled = 1'b1;
  endtask

  // Result side stalls at random while idling is enabled
  always @(posedge clk) begin
    if (idle_enabled) out_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    else out_bus.ready <= 1'b1;
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    dibit_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no pending expectation");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("valid_res", want.valid_res, out_bus.valid_res);
        check_field("channel", want.channel, out_bus.channel);
        check_field("position", want.position, out_bus.position);
        check_field("tag", want.tag, out_bus.tag);
        check_field("mode_state", want.mode_state, out_bus.mode_state);
        check_field("overflow", want.overflow, out_bus.overflow);
      end
    end
  end

  // End the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    in_bus.valid           <= 1'b0;
    in_bus.kind            <= KIND_HEADER;
    in_bus.frame_indicator <= FI_HEADER;
    in_bus.frame_number    <= FN_FIRST;
    in_bus.data_type       <= DT_UNKNOWN;
    seg_head       = 0;
    seg_tail       = 0;
    seg_count      = 0;
    planner_mode_q = MODE_DONE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_header_plans();
    test_drain_and_pause();
    test_random_traffic();

    // Let the last results drain out
    in_bus.valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
